// ===== design/fisr_pkg.sv =====
// Shared constants, types and single-precision arithmetic functions.
package fisr_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned QueueDepth = 4;
	localparam logic [31:0] MagicGuess = 32'h5f3759df;
	localparam logic [31:0] CanonNan = 32'h7fc00000;
	localparam logic [31:0] FpHalf = 32'h3f000000;
	localparam logic [31:0] FpThreeHalves = 32'h3fc00000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] g;
	} fisr_item_t;

	// Unpacked operand: exponent as biased value (subnormals get 1), significand with hidden bit.
	typedef struct packed {
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic [9:0]  exp;
		logic [23:0] man;
	} fp_unp_t;

	typedef struct packed {
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic signed [10:0] exp;
		logic [49:0] man;
	} fp_mid_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] a);
		fp_unp_t u;
		u.sign = a[31];
		u.is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		u.is_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		u.is_zero = (a[30:0] == 31'd0);
		u.exp = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
		u.man = {(a[30:23] != 8'd0), a[22:0]};
		return u;
	endfunction

	// Round a positive magnitude to single precision, nearest even.
	// man holds its leading one anywhere in bits 49..0; value = man * 2^(exp - 127 - 46).
	function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] exp,
			input logic [49:0] man);
		logic [5:0]  lz;
		logic [49:0] nm;
		logic signed [11:0] e;
		logic [5:0]  sh;
		logic [50:0] ext;
		logic        sticky;
		logic [24:0] kept;
		logic        g;
		logic [25:0] rnd;
		logic [31:0] res;
		lz = 6'd0;
		for (int i = 0; i < 50; i++) begin
			if (man[i]) lz = 6'(49 - i);
		end
		nm = man << lz;
		// leading one now at bit 49 => value 1.x * 2^(exp + 3 - lz - 127)
		e = 12'(exp) + 12'sd3 - 12'($signed({1'b0, lz}));
		sh = 6'd0;
		if (e < 12'sd1) begin
			sh = (e < -12'sd30) ? 6'd31 : 6'(12'sd1 - e);
			e = 12'sd0;
		end
		ext = {nm, 1'b0} >> sh;
		sticky = 1'b0;
		for (int i = 0; i < 50; i++) begin
			if (i < int'(sh) && nm[i]) sticky = 1'b1;
		end
		kept = {1'b0, ext[50:27]};
		g = ext[26];
		sticky = sticky | (ext[25:0] != 26'd0);
		rnd = {1'b0, kept} + 26'(g && (sticky || kept[0]));
		// A subnormal that rounds up into the hidden bit becomes the smallest normal.
		if (rnd[23] && !kept[23] && e == 12'sd0) e = 12'sd1;
		if (rnd[24]) begin
			rnd = rnd >> 1;
			e = e + 12'sd1;
		end
		if (e >= 12'sd255) res = {sign, 8'hff, 23'd0};
		else res = {sign, e[7:0], rnd[22:0]};
		if (man == 50'd0) res = {sign, 31'd0};
		return res;
	endfunction

	// Multiply, first half: specials and the significand product.
	function automatic fp_mid_t fp_mul_a(input logic [31:0] a, input logic [31:0] b);
		fp_unp_t ua;
		fp_unp_t ub;
		fp_mid_t m;
		ua = fp_unpack(a);
		ub = fp_unpack(b);
		m.sign = ua.sign ^ ub.sign;
		m.is_nan = ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
			(ub.is_inf && ua.is_zero);
		m.is_inf = ua.is_inf || ub.is_inf;
		m.is_zero = ua.is_zero || ub.is_zero;
		// product exponent: ea+eb-127, product has leading one at bit 46 or 47 for normal operands
		m.exp = 11'($signed({1'b0, ua.exp})) + 11'($signed({1'b0, ub.exp})) - 11'sd127;
		m.man = {2'b00, 48'(ua.man) * 48'(ub.man)};
		return m;
	endfunction

	function automatic logic [31:0] fp_finish(input fp_mid_t m);
		if (m.is_nan) return CanonNan;
		if (m.is_inf) return {m.sign, 8'hff, 23'd0};
		if (m.is_zero) return {m.sign, 31'd0};
		return fp_round(m.sign, m.exp, m.man);
	endfunction

	// 1.5 - t, exact alignment then one rounding.
	function automatic logic [31:0] fp_sub_from_1p5(input logic [31:0] t);
		fp_unp_t ua;
		fp_unp_t ub;
		logic [10:0] d;
		logic [49:0] ma;
		logic [49:0] mb;
		logic        st;
		logic        bs;
		logic        big_a;
		logic [10:0] eb;
		logic [49:0] mr;
		logic        rs;
		ua = fp_unpack(FpThreeHalves);
		ub = fp_unpack(t);
		bs = ~ub.sign;
		if (ub.is_nan) return CanonNan;
		if (ub.is_inf) return {bs, 8'hff, 23'd0};
		if (ub.is_zero) return FpThreeHalves;
		big_a = {ua.exp, ua.man} >= {ub.exp, ub.man};
		if (big_a) begin
			d = 11'(ua.exp) - 11'(ub.exp);
			ma = {1'b0, ua.man, 25'd0};
			mb = {1'b0, ub.man, 25'd0};
			eb = 11'(ua.exp);
		end else begin
			d = 11'(ub.exp) - 11'(ua.exp);
			ma = {1'b0, ub.man, 25'd0};
			mb = {1'b0, ua.man, 25'd0};
			eb = 11'(ub.exp);
		end
		st = 1'b0;
		if (d > 11'd48) begin
			st = (mb != 50'd0);
			mb = 50'd0;
		end else begin
			for (int i = 0; i < 50; i++) begin
				if (i < int'(d) && mb[i]) st = 1'b1;
			end
			mb = mb >> d;
		end
		rs = big_a ? ua.sign : bs;
		if (ua.sign == bs) mr = ma + mb + 50'(st);
		else mr = ma - mb - 50'(st);
		if (mr == 50'd0) return 32'd0;
		// mr value: mr * 2^(eb - 127 - 48); fp_round expects exponent offset of 46
		mr = {mr[49:1], mr[0] | st};
		return fp_round(rs, $signed(eb) - 11'sd2, mr);
	endfunction
endpackage

// ===== design/fast_inverse_square_root.sv =====
// An accepted input is written to the front queue and then registered through the back stages in order.
// Throughput: one item per cycle while the output does not stall; the front queue holds four items and the
// nine-stage back pipeline advances each stage whenever the next can take it.
// Reset (arst_n low) empties the queue and the pipeline at once; no item is lost
// or repeated afterwards since no state outlives an item.
// Top level of the fast reciprocal square root block.
module fast_inverse_square_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] y_bits
);
	import fisr_pkg::*;

	logic       q_valid;
	logic       q_ready;
	fisr_item_t q_item;

	fisr_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.x_bits(x_bits), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	fisr_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .valid(out_valid), .ready(out_ready), .y_bits(y_bits)
	);
endmodule

// ===== design/fisr_front.sv =====
// Front end: accepts inputs, forms the integer guess and queues the item.
module fisr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [31:0]        x_bits,
	output logic               q_valid,
	input  logic               q_ready,
	output fisr_pkg::fisr_item_t q_item
);
	import fisr_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);
	fisr_item_t       mem_q [QueueDepth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [PtrW:0]    cnt_q;
	logic             push;
	logic             pop;
	fisr_item_t       item;

	always_comb begin
		item.x = x_bits;
		item.g = MagicGuess - {x_bits[31], x_bits[31:1]};
	end

	assign ready = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push = valid && ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule

// ===== design/fisr_back.sv =====
// Back end: pipelined Newton step with a stall-capable elastic pipeline.
module fisr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  fisr_pkg::fisr_item_t q_item,
	output logic               valid,
	input  logic               ready,
	output logic [31:0]        y_bits
);
	import fisr_pkg::*;

	// Stages: 1 half product, 2 half rounded, 3 hg product, 4 hg rounded,
	// 5 t product, 6 t rounded, 7 r, 8 y product, 9 y rounded.
	localparam int unsigned NSt = 9;
	logic [NSt:1] v_q;
	logic [NSt:1] adv;
	logic [31:0]  g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7;
	fp_mid_t      m_s1, m_s3, m_s5, m_s8;
	logic [31:0]  h_s2, hg_s4, t_s6, r_s7, y_s9;

	always_comb begin
		adv[NSt] = !v_q[NSt] || ready;
		for (int i = NSt - 1; i >= 1; i--) adv[i] = !v_q[i] || adv[i+1];
	end

	assign q_ready = adv[1];
	assign valid = v_q[NSt];
	assign y_bits = y_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else begin
			if (adv[1]) v_q[1] <= q_valid;
			for (int i = 2; i <= NSt; i++) begin
				if (adv[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_s1 <= fp_mul_a(FpHalf, q_item.x);
			g_s1 <= q_item.g;
		end
		if (adv[2]) begin
			h_s2 <= fp_finish(m_s1);
			g_s2 <= g_s1;
		end
		if (adv[3]) begin
			m_s3 <= fp_mul_a(h_s2, g_s2);
			g_s3 <= g_s2;
		end
		if (adv[4]) begin
			hg_s4 <= fp_finish(m_s3);
			g_s4 <= g_s3;
		end
		if (adv[5]) begin
			m_s5 <= fp_mul_a(hg_s4, g_s4);
			g_s5 <= g_s4;
		end
		if (adv[6]) begin
			t_s6 <= fp_finish(m_s5);
			g_s6 <= g_s5;
		end
		if (adv[7]) begin
			r_s7 <= fp_sub_from_1p5(t_s6);
			g_s7 <= g_s6;
		end
		if (adv[8]) m_s8 <= fp_mul_a(g_s7, r_s7);
		if (adv[9]) y_s9 <= fp_finish(m_s8);
	end
endmodule
